@@ design/ptit_pkg.sv @@
// Package for the periodic task interval table: slot count, request and
// result codes, sequencer states. No dependencies.
`default_nettype none

package ptit_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EXISTS   = 3'd4,
    ST_ABSENT   = 3'd5,
    ST_FIRES    = 3'd6,
    ST_NONE     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FLUSH = 2'd2
  } state_t;

endpackage

`default_nettype wire

@@ design/ptit_req_if.sv @@
// Request channel of the periodic task interval table: valid/ready and payload.
// Depends on nothing.
`default_nettype none

interface ptit_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  task_id;
  logic [31:0] period;
  logic [31:0] current_time;

  modport source (output valid, opcode, task_id, period, current_time, input ready);
  modport sink   (input valid, opcode, task_id, period, current_time, output ready);
endinterface

`default_nettype wire

@@ design/ptit_rsp_if.sv @@
// Result channel of the periodic task interval table: valid/ready and payload.
// Depends on nothing.
`default_nettype none

interface ptit_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] fired_id;
  logic       last_of_run;

  modport source (output valid, status, fired_id, last_of_run, input ready);
  modport sink   (input valid, status, fired_id, last_of_run, output ready);
endinterface

`default_nettype wire

@@ design/periodic_task_interval_table.sv @@
// Periodic task interval table: slot registers scanned by one due-time unit.
// Depends on ptit_pkg, ptit_req_if and ptit_rsp_if.
// Sequence: a request visits the slots one per cycle, while a tick is not held
// (add, remove and query stop at the slot that settles them, a tick visits every
// slot), then posts its final result from S_FLUSH. A new request is taken only in
// S_IDLE, after the single slot scan of the last one; a request stalls while one of
// its results cannot be posted. Reset: synchronous active-low rst_n frees every slot and empties the output.
`default_nettype none

module periodic_task_interval_table
  import ptit_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  ptit_req_if.sink   in_ch,
  ptit_rsp_if.source out_ch
);

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  opcode_t             op_r, op_nxt;
  logic [7:0]          id_r, id_nxt;
  logic [31:0]         per_r, per_nxt;
  logic [31:0]         now_r, now_nxt;

  logic                pend_v_r, pend_v_nxt;
  status_t             pend_st_r, pend_st_nxt;
  logic [7:0]          pend_id_r, pend_id_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [7:0]          out_id_r, out_id_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;
  logic                out_free;

  logic [NUM_SLOTS-1:0] slot_valid_r;
  logic [7:0]           slot_task_r   [NUM_SLOTS];
  logic [31:0]          slot_period_r [NUM_SLOTS];
  logic [31:0]          slot_last_r   [NUM_SLOTS];

  logic        set_slot, clr_slot, touch_slot;
  logic        cur_valid;
  logic [7:0]  cur_task;
  logic [31:0] cur_last;
  logic [32:0] thr_sum;
  logic        due, match, at_end;

  assign cur_valid = slot_valid_r[idx_r];
  assign cur_task  = slot_task_r[idx_r];
  assign cur_last  = slot_last_r[idx_r];
  assign thr_sum   = {1'b0, cur_last} + {1'b0, slot_period_r[idx_r]};
  assign due       = thr_sum[32] ? ((now_r <= cur_last) && (now_r >= thr_sum[31:0]))
                                 : (now_r >= thr_sum[31:0]);
  assign match     = cur_valid && (cur_task == id_r);
  assign at_end    = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.fired_id    = out_id_r;
  assign out_ch.last_of_run = out_last_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    per_nxt     = per_r;
    now_nxt     = now_r;
    pend_v_nxt  = pend_v_r;
    pend_st_nxt = pend_st_r;
    pend_id_nxt = pend_id_r;
    out_load    = 1'b0;
    out_st_nxt  = out_st_r;
    out_id_nxt  = out_id_r;
    out_last_nxt = out_last_r;
    set_slot    = 1'b0;
    clr_slot    = 1'b0;
    touch_slot  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = opcode_t'(in_ch.opcode);
          id_nxt     = in_ch.task_id;
          per_nxt    = in_ch.period;
          now_nxt    = in_ch.current_time;
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (op_r)
          OP_ADD: begin
            if (!cur_valid) begin
              set_slot    = 1'b1;
              pend_v_nxt  = 1'b1;
              pend_st_nxt = ST_ADDED;
              pend_id_nxt = id_r;
              state_nxt   = S_FLUSH;
            end else if (at_end) begin
              pend_v_nxt  = 1'b1;
              pend_st_nxt = ST_FULL;
              pend_id_nxt = id_r;
              state_nxt   = S_FLUSH;
            end else begin
              idx_nxt = idx_r + SLOT_W'(1);
            end
          end
          OP_REMOVE: begin
            if (match) begin
              clr_slot    = 1'b1;
              pend_v_nxt  = 1'b1;
              pend_st_nxt = ST_REMOVED;
              pend_id_nxt = id_r;
              state_nxt   = S_FLUSH;
            end else if (at_end) begin
              pend_v_nxt  = 1'b1;
              pend_st_nxt = ST_NOTFOUND;
              pend_id_nxt = id_r;
              state_nxt   = S_FLUSH;
            end else begin
              idx_nxt = idx_r + SLOT_W'(1);
            end
          end
          OP_QUERY: begin
            if (match || at_end) begin
              pend_v_nxt  = 1'b1;
              pend_st_nxt = match ? ST_EXISTS : ST_ABSENT;
              pend_id_nxt = id_r;
              state_nxt   = S_FLUSH;
            end else begin
              idx_nxt = idx_r + SLOT_W'(1);
            end
          end
          OP_TICK: begin
            // hold the scan while a due slot finds an earlier fire still waiting for the output
            if (!(cur_valid && due && pend_v_r && !out_free)) begin
              if (cur_valid && due) begin
                if (pend_v_r) begin
                  out_load     = 1'b1;
                  out_st_nxt   = ST_FIRES;
                  out_id_nxt   = pend_id_r;
                  out_last_nxt = 1'b0;
                end
                touch_slot  = 1'b1;
                pend_v_nxt  = 1'b1;
                pend_st_nxt = ST_FIRES;
                pend_id_nxt = cur_task;
              end
              if (at_end) begin
                state_nxt = S_FLUSH;
              end else begin
                idx_nxt = idx_r + SLOT_W'(1);
              end
            end
          end
        endcase
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_st_nxt   = pend_v_r ? pend_st_r : ST_NONE;
          out_id_nxt   = pend_v_r ? pend_id_r : id_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pend_v_r     <= 1'b0;
      slot_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      if (set_slot) begin
        slot_valid_r[idx_r] <= 1'b1;
      end else if (clr_slot) begin
        slot_valid_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    per_r     <= per_nxt;
    now_r     <= now_nxt;
    pend_st_r <= pend_st_nxt;
    pend_id_r <= pend_id_nxt;
    if (out_load) begin
      out_st_r   <= out_st_nxt;
      out_id_r   <= out_id_nxt;
      out_last_r <= out_last_nxt;
    end
    if (set_slot) begin
      slot_task_r[idx_r]   <= id_r;
      slot_period_r[idx_r] <= per_r;
    end
    if (set_slot || touch_slot) begin
      slot_last_r[idx_r] <= now_r;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_periodic_task_interval_table.sv @@
// Testbench for periodic_task_interval_table: directed and random requests with a
// built-in slot table predictor, random stalls on both channels and result checks.
// Depends on ptit_pkg, ptit_req_if, ptit_rsp_if and the table RTL.
`default_nettype none

module tb_periodic_task_interval_table
  import ptit_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t    status;
    logic [7:0] id;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  ptit_req_if req_ch ();
  ptit_rsp_if rsp_ch ();

  periodic_task_interval_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  always #5 clk = ~clk;

  // predicted slot table
  logic        table_valid  [NUM_SLOTS];
  logic [7:0]  table_id     [NUM_SLOTS];
  logic [31:0] table_period [NUM_SLOTS];
  logic [31:0] table_last   [NUM_SLOTS];

  result_t     pending_results[$];
  int          mismatch_count = 0;
  logic        quiet = 1'b0;
  logic        sender_gaps = 1'b1;
  int          long_stall_cycles = 0;
  logic [31:0] clock_now = 32'h0;

  function automatic logic task_due(input logic [31:0] last, input logic [31:0] per,
                                    input logic [31:0] now);
    logic [31:0] thr;
    thr = last + per;
    if (thr < last) return (now <= last) && (now >= thr);
    return now >= thr;
  endfunction

  function automatic void push_result(input status_t st, input logic [7:0] id,
                                      input logic last);
    result_t r;
    r.status = st;
    r.id     = id;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_request(input opcode_t op, input logic [7:0] id,
                                        input logic [31:0] per, input logic [31:0] now);
    int hit;
    int fired;
    int n;
    logic [NUM_SLOTS-1:0] due_mask;
    hit = -1;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (hit < 0 && !table_valid[i]) hit = i;
        if (hit >= 0) begin
          table_valid[hit]  = 1'b1;
          table_id[hit]     = id;
          table_period[hit] = per;
          table_last[hit]   = now;
          push_result(ST_ADDED, id, 1'b1);
        end else begin
          push_result(ST_FULL, id, 1'b1);
        end
      end
      OP_REMOVE, OP_QUERY: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (hit < 0 && table_valid[i] && table_id[i] == id) hit = i;
        if (op == OP_REMOVE) begin
          if (hit >= 0) table_valid[hit] = 1'b0;
          push_result(hit >= 0 ? ST_REMOVED : ST_NOTFOUND, id, 1'b1);
        end else begin
          push_result(hit >= 0 ? ST_EXISTS : ST_ABSENT, id, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          due_mask[i] = table_valid[i] && task_due(table_last[i], table_period[i], now);
        n = $countones(due_mask);
        fired = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (due_mask[i]) begin
            fired++;
            table_last[i] = now;
            push_result(ST_FIRES, table_id[i], fired == n);
          end
        end
        if (n == 0) push_result(ST_NONE, id, 1'b1);
      end
    endcase
  endfunction

  task automatic send_request(input opcode_t op, input logic [7:0] id,
                              input logic [31:0] per, input logic [31:0] now);
    int gap;
    if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    req_ch.valid        = 1'b1;
    req_ch.opcode       = op;
    req_ch.task_id      = id;
    req_ch.period       = per;
    req_ch.current_time = now;
    do @(posedge clk); while (!req_ch.ready);
    apply_request(op, id, per, now);
  endtask

  task automatic clear_table();
    int first;
    first = 0;
    while (first >= 0) begin
      first = -1;
      for (int i = 0; i < NUM_SLOTS; i++)
        if (first < 0 && table_valid[i]) first = i;
      if (first >= 0) send_request(OP_REMOVE, table_id[first], $urandom(), clock_now);
    end
  endtask

  task automatic test_empty_table();
    send_request(OP_QUERY, 8'h5A, 32'h0, 32'h0);
    send_request(OP_REMOVE, 8'hA5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_TICK, 8'hFF, 32'h0, 32'h0);
  endtask

  task automatic test_fill_and_full();
    send_request(OP_ADD, 8'h00, 32'h0, 32'h1000);
    send_request(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'h1000);
    send_request(OP_ADD, 8'h00, 32'd10, 32'h1000);
    send_request(OP_ADD, 8'h81, 32'h8000_0000, 32'h1000);
    send_request(OP_ADD, 8'h42, 32'h7FFF_FFFF, 32'h1000);
    send_request(OP_ADD, 8'h18, 32'd1, 32'h1000);
    send_request(OP_ADD, 8'h24, 32'd2, 32'h1000);
    send_request(OP_ADD, 8'h3C, 32'd3, 32'h1000);
    send_request(OP_ADD, 8'h99, 32'd5, 32'h1000);
    send_request(OP_QUERY, 8'h00, 32'h0, 32'h1000);
    send_request(OP_QUERY, 8'h99, 32'h0, 32'h1000);
  endtask

  task automatic test_wrap_threshold();
    send_request(OP_TICK, 8'h01, 32'h0, 32'h1000);
    send_request(OP_TICK, 8'h02, 32'h0, 32'h100A);
    send_request(OP_TICK, 8'h03, 32'h0, 32'h8000_1000);
    send_request(OP_TICK, 8'h04, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_TICK, 8'h05, 32'h0, 32'h0);
  endtask

  task automatic test_remove_duplicates();
    send_request(OP_REMOVE, 8'h00, 32'h0, 32'h0);
    send_request(OP_QUERY, 8'h00, 32'h0, 32'h0);
    send_request(OP_REMOVE, 8'h00, 32'h0, 32'h0);
    send_request(OP_QUERY, 8'h00, 32'h0, 32'h0);
    send_request(OP_REMOVE, 8'h00, 32'h0, 32'h0);
  endtask

  task automatic test_backpressure();
    clock_now = 32'h0001_2345;
    clear_table();
    for (int i = 0; i < NUM_SLOTS; i++)
      send_request(OP_ADD, 8'(8'hE0 + i), 32'h0, clock_now);
    sender_gaps = 1'b0;
    long_stall_cycles = 300;
    repeat (16) begin
      clock_now = clock_now + 1;
      send_request(OP_TICK, 8'($urandom_range(0, 255)), $urandom(), clock_now);
    end
    sender_gaps = 1'b1;
  endtask

  task automatic send_random_request();
    opcode_t     op;
    logic [7:0]  id;
    logic [31:0] per;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) op = OP_ADD;
    else if (pick < 40) op = OP_REMOVE;
    else if (pick < 55) op = OP_QUERY;
    else op = OP_TICK;
    id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 11)) : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 70) per = $urandom_range(0, 40);
    else if (pick < 85) per = $urandom();
    else per = 32'hFFFF_FFFF - $urandom_range(0, 40);
    if ($urandom_range(0, 39) == 0) clock_now = $urandom();
    else clock_now = clock_now + $urandom_range(0, 20);
    send_request(op, id, per, clock_now);
  endtask

  task automatic test_random_traffic(input int count);
    clock_now = 32'hFFFF_FC00;
    clear_table();
    repeat (count) send_random_request();
  endtask

  task automatic test_quiet_traffic(input int count);
    quiet = 1'b1;
    repeat (count) send_random_request();
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_cycles > 0) begin
        long_stall_cycles--;
        rsp_ch.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        long_stall_cycles = $urandom_range(0, 12);
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: expected no result, actual status=%0d id=%0h last=%0b", $time,
                 rsp_ch.status, rsp_ch.fired_id, rsp_ch.last_of_run);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.fired_id !== want.id) begin
          $display("%0t: fired_id expected %0h actual %0h", $time, want.id, rsp_ch.fired_id);
          mismatch_count++;
        end
        if (rsp_ch.last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, want.last,
                   rsp_ch.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) table_valid[i] = 1'b0;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = OP_ADD;
    req_ch.task_id      = 8'h0;
    req_ch.period       = 32'h0;
    req_ch.current_time = 32'h0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_fill_and_full();
    test_wrap_threshold();
    test_remove_duplicates();
    test_backpressure();
    test_random_traffic(200);
    test_quiet_traffic(60);

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * NUM_SLOTS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/ptit_pkg.sv
design/ptit_req_if.sv
design/ptit_rsp_if.sv
design/periodic_task_interval_table.sv
sim/tb_periodic_task_interval_table.sv
